FILE: rtl/core/itrd_pkg.sv
`timescale 1ns / 1ps
package itrd_pkg;

   localparam int RADIX_BITS      = 5;
   localparam int LENGTH_BITS     = 6;
   localparam int CHAR_BITS       = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 6;

   localparam logic [RADIX_BITS-1:0]  RADIX_MIN       = 5'd2;
   localparam logic [RADIX_BITS-1:0]  RADIX_MAX       = 5'd16;
   localparam logic [RADIX_BITS-1:0]  RADIX_RESET     = 5'd10;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET    = 6'd32;
   localparam logic [CHAR_BITS-1:0]   CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_BITS-1:0]   CHAR_LETTER_A   = 8'h41;
   localparam logic [CHAR_BITS-1:0]   CHAR_NUL        = 8'h00;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RADIX         = 2'd0,
      REG_BUFFER_LENGTH = 2'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OK              = 2'd0,
      ST_BAD_SETTING     = 2'd1,
      ST_RADIX_TOO_LARGE = 2'd2,
      ST_NO_SPACE        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_EMIT
   } state_type;

   // Handshake between the sequencer and the serial divider.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Maps a remainder of 0..15 onto '0'-'9' and 'A'-'F'.
   function automatic logic [CHAR_BITS-1:0] glyph(input logic [3:0] digit);
      logic [CHAR_BITS-1:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {4'd0, digit};
      end else begin
         result = CHAR_LETTER_A + {4'd0, digit - 4'd10};
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/itrd_if.sv
`timescale 1ns / 1ps
interface itrd_req_if #(parameter int VALUE_BITS = 31);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface itrd_rsp_if import itrd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CHAR_BITS-1:0]   digit_char;
   logic                   last;
   logic [1:0]             status;
   logic [LENGTH_BITS-1:0] digit_count;
   modport source (output valid, output digit_char, output last, output status,
                   output digit_count, input ready);
   modport sink (input valid, input digit_char, input last, input status,
                 input digit_count, output ready);
endinterface

interface itrd_csr_if import itrd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/itrd_div.sv
`timescale 1ns / 1ps
module itrd_div import itrd_pkg::*; #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] radix,
   output div_stat_type          stat,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [3:0]            remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [RADIX_BITS-1:0] r_ff, r_in;
   logic [RADIX_BITS-1:0] trial;
   logic                  fits;

   // Restoring division, one quotient bit per cycle: the dividend shifts
   // out at the top while the quotient bits shift in at the bottom.
   always_comb begin
      trial   = {r_ff[RADIX_BITS-2:0], q_ff[VALUE_BITS-1]};
      fits    = (trial >= radix);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         q_in   = {q_ff[VALUE_BITS-2:0], fits};
         r_in   = fits ? trial - radix : trial;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[3:0];

endmodule

FILE: rtl/core/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Integer to ASCII digits in a radix of 2 to 16, least significant digit first.
// req_bus carries one non-negative value per beat; rsp_bus returns one beat per
// digit, the final beat marked by last and carrying status and digit count.
// csr_bus writes radix (index 0) and buffer_length (index 1); it is always
// ready and should only be used while no conversion is in flight.
// Each digit comes from a bit-serial restoring divider that retires one
// quotient bit per cycle; once the division of VALUE_BITS bits is done, the
// digit is captured in a holding register and then handed to the output
// register, which also starts the next division. A bad or too-large radix, or
// a zero buffer length, answers with a single beat that passes through the
// holding register into the output register.
// Only one value is converted at a time; req_bus is ready again once the final
// beat sits in the output register, even if the receiver has not taken it.
// When rsp_bus stalls, the finished digit waits in the output register, the
// next one waits in a holding register, and the divider idles until both move.
// Reset is synchronous; it restores radix 10 and buffer length 32 and drops
// any conversion in progress.
module integer_to_radix_digits import itrd_pkg::*; #(
   parameter int VALUE_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   itrd_req_if.sink    req_bus,
   itrd_rsp_if.source  rsp_bus,
   itrd_csr_if.sink    csr_bus
);

   state_type              state_ff, state_in;
   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0]  quot_ff, quot_in;

   logic [CHAR_BITS-1:0]   pend_char_ff, pend_char_in;
   logic                   pend_last_ff, pend_last_in;
   status_type             pend_status_ff, pend_status_in;
   logic [LENGTH_BITS-1:0] pend_count_ff, pend_count_in;

   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]   out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;
   status_type             out_status_ff, out_status_in;
   logic [LENGTH_BITS-1:0] out_count_ff, out_count_in;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;
   logic [VALUE_BITS-1:0]  div_dividend;
   logic [VALUE_BITS-1:0]  div_quot;
   logic [3:0]             div_rem;

   logic                   req_fire;
   logic                   out_free;
   logic [LENGTH_BITS-1:0] count_next;
   logic                   full;

   itrd_div #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign count_next    = count_ff + 1'b1;
   assign full          = (count_next >= length_ff);

   always_comb begin
      radix_in  = radix_ff;
      length_in = length_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_RADIX:         radix_in  = csr_bus.data[RADIX_BITS-1:0];
            REG_BUFFER_LENGTH: length_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      quot_in        = quot_ff;
      pend_char_in   = pend_char_ff;
      pend_last_in   = pend_last_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      div_ctrl.start = 1'b0;
      div_dividend   = quot_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_char_in    = out_char_ff;
      out_last_in    = out_last_ff;
      out_status_in  = out_status_ff;
      out_count_in   = out_count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pend_char_in  = CHAR_NUL;
               pend_last_in  = 1'b1;
               pend_count_in = '0;
               if (radix_ff < RADIX_MIN || length_ff == '0) begin
                  pend_status_in = ST_BAD_SETTING;
                  state_in       = S_EMIT;
               end else if (radix_ff > RADIX_MAX) begin
                  pend_status_in = ST_RADIX_TOO_LARGE;
                  state_in       = S_EMIT;
               end else begin
                  count_in       = '0;
                  div_dividend   = req_bus.value;
                  div_ctrl.start = 1'b1;
                  state_in       = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            if (div_stat.done) begin
               quot_in  = div_quot;
               count_in = count_next;
               // A full buffer ends the string even when the number is done.
               if (full) begin
                  pend_char_in   = CHAR_NUL;
                  pend_last_in   = 1'b1;
                  pend_status_in = ST_NO_SPACE;
                  pend_count_in  = count_ff;
               end else if (div_quot == '0) begin
                  pend_char_in   = glyph(div_rem);
                  pend_last_in   = 1'b1;
                  pend_status_in = ST_OK;
                  pend_count_in  = count_next;
               end else begin
                  pend_char_in   = glyph(div_rem);
                  pend_last_in   = 1'b0;
                  pend_status_in = ST_OK;
                  pend_count_in  = '0;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_char_in   = pend_char_ff;
               out_last_in   = pend_last_ff;
               out_status_in = pend_status_ff;
               out_count_in  = pend_count_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = S_DIVIDE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radix_ff     <= RADIX_RESET;
         length_ff    <= LENGTH_RESET;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      quot_ff        <= quot_in;
      pend_char_ff   <= pend_char_in;
      pend_last_ff   <= pend_last_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      out_char_ff    <= out_char_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
      out_count_ff   <= out_count_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.digit_char  = out_char_ff;
   assign rsp_bus.last        = out_last_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.digit_count = out_count_ff;

`ifndef SYNTH
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !div_stat.busy && !div_stat.done)
      else $error("divider active while accepting a new value");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside the divide state");

   a_inner_beat_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last |-> rsp_bus.status == ST_OK &&
         rsp_bus.digit_count == '0 && rsp_bus.digit_char != CHAR_NUL)
      else $error("non-final beat carries status, count or a zero byte");

   a_ok_has_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last && rsp_bus.status == ST_OK |->
         rsp_bus.digit_count != '0)
      else $error("successful conversion reports no digits");
`endif

endmodule
